[rtl/modbus_request_pdu_serializer_defines.svh]
// ----------------------------------------------------------------------------
// Modbus request PDU serializer assertion macros
// Shared macros for the concurrent checks on the serializer ports.
// ----------------------------------------------------------------------------
`ifndef MODBUS_REQUEST_PDU_SERIALIZER_DEFINES_SVH
`define MODBUS_REQUEST_PDU_SERIALIZER_DEFINES_SVH

// check a property outside reset
`define MRPS_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("mrps check failed");

// check a property at every edge, reset included
`define MRPS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mrps check failed");

`endif

[rtl/mrps_pkg.sv]
// ----------------------------------------------------------------------------
// Modbus request PDU serializer package
// Job record passed from the front to the back, and request kind constants.
// ----------------------------------------------------------------------------
package mrps_pkg;

  localparam int unsigned JobBytes = 10;

  localparam logic [3:0] KIND_READ_HOLD_MAX = 4'd3;
  localparam logic [3:0] KIND_WRITE_COIL    = 4'd4;
  localparam logic [3:0] KIND_WRITE_REG     = 4'd5;
  localparam logic [3:0] KIND_WRITE_COILS   = 4'd6;
  localparam logic [3:0] KIND_WRITE_REGS    = 4'd7;
  localparam logic [3:0] KIND_READ_WRITE    = 4'd8;

  localparam logic [0:0] CMD_HEADER = 1'b0;
  localparam logic [0:0] CMD_VALUE  = 1'b1;

  localparam logic [15:0] COIL_ON  = 16'hff00;
  localparam logic [15:0] COIL_OFF = 16'h0000;

  typedef enum logic [1:0] {
    COLL_IDLE,
    COLL_COILS,
    COLL_REGS
  } coll_e;

  // one block of bytes to send, first byte at index 0
  typedef struct packed {
    logic [JobBytes-1:0][7:0] data;
    logic [3:0]               len;
    logic [7:0]               slave;
    logic                     last;
    logic                     ovf;
  } job_t;

  function automatic logic [7:0] kind_code(input logic [3:0] kind);
    logic [7:0] code;
    case (kind)
      4'd0:    code = 8'd1;
      4'd1:    code = 8'd2;
      4'd2:    code = 8'd3;
      4'd3:    code = 8'd4;
      4'd4:    code = 8'd5;
      4'd5:    code = 8'd6;
      4'd6:    code = 8'd15;
      4'd7:    code = 8'd16;
      4'd8:    code = 8'd23;
      default: code = 8'd0;
    endcase
    return code;
  endfunction

endpackage

[rtl/mrps_fifo.sv]
// ----------------------------------------------------------------------------
// Modbus request PDU serializer job queue
// Small queue of byte jobs between the front and the back.
// ----------------------------------------------------------------------------
module mrps_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mrps_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output mrps_pkg::job_t rdata_o
);
  import mrps_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/mrps_front.sv]
// ----------------------------------------------------------------------------
// Modbus request PDU serializer front end
// Accepts headers and value items, tracks the request and builds byte jobs.
// ----------------------------------------------------------------------------
module mrps_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic           cmd_i,
  input  logic [3:0]     kind_i,
  input  logic [7:0]     slave_i,
  input  logic [15:0]    address_i,
  input  logic [15:0]    quantity_i,
  input  logic [15:0]    single_value_i,
  input  logic [15:0]    write_address_i,
  input  logic [15:0]    write_quantity_i,
  input  logic [15:0]    element_i,
  output logic           job_valid_o,
  output mrps_pkg::job_t job_o
);
  import mrps_pkg::*;

  coll_e       coll_q, coll_d;
  logic [15:0] left_q, left_d;
  logic [7:0]  acc_q, acc_d;
  logic [2:0]  pos_q, pos_d;
  logic [7:0]  slave_q, slave_d;

  logic [13:0] coil_cnt;
  logic [15:0] left_dec;
  logic [2:0]  pos_inc;
  logic [7:0]  acc_set;
  logic [15:0] wq;
  logic [15:0] cval;

  always_comb begin
    coil_cnt = {1'b0, quantity_i[15:3]} + {13'd0, |quantity_i[2:0]};
    left_dec = left_q - 16'd1;
    pos_inc  = pos_q + 3'd1;
    acc_set  = acc_q | (8'(element_i != 16'd0) << pos_q);
    wq       = (kind_i == KIND_READ_WRITE) ? write_quantity_i : quantity_i;
    cval     = (single_value_i != 16'd0) ? COIL_ON : COIL_OFF;

    coll_d  = coll_q;
    left_d  = left_q;
    acc_d   = acc_q;
    pos_d   = pos_q;
    slave_d = slave_q;

    job_valid_o = 1'b0;
    job_o       = '0;
    job_o.slave = slave_q;

    if (accept_i && (cmd_i == CMD_HEADER)) begin
      coll_d      = COLL_IDLE;
      left_d      = '0;
      acc_d       = '0;
      pos_d       = '0;
      slave_d     = slave_i;
      job_o.slave = slave_i;
      job_o.data[0] = kind_code(kind_i);
      job_o.data[1] = address_i[15:8];
      job_o.data[2] = address_i[7:0];
      job_valid_o   = (kind_i <= KIND_READ_WRITE);
      if (kind_i <= KIND_READ_HOLD_MAX) begin
        job_o.data[3] = quantity_i[15:8];
        job_o.data[4] = quantity_i[7:0];
        job_o.len     = 4'd5;
        job_o.last    = 1'b1;
      end else if (kind_i == KIND_WRITE_COIL) begin
        job_o.data[3] = cval[15:8];
        job_o.data[4] = cval[7:0];
        job_o.len     = 4'd5;
        job_o.last    = 1'b1;
      end else if (kind_i == KIND_WRITE_REG) begin
        job_o.data[3] = single_value_i[15:8];
        job_o.data[4] = single_value_i[7:0];
        job_o.len     = 4'd5;
        job_o.last    = 1'b1;
      end else if (kind_i == KIND_WRITE_COILS) begin
        job_o.data[3] = quantity_i[15:8];
        job_o.data[4] = quantity_i[7:0];
        job_o.data[5] = coil_cnt[7:0];
        job_o.len     = 4'd6;
        job_o.last    = (quantity_i == 16'd0);
        job_o.ovf     = |coil_cnt[13:8];
        if (quantity_i != 16'd0) begin
          coll_d = COLL_COILS;
          left_d = quantity_i;
        end
      end else if (kind_i == KIND_WRITE_REGS) begin
        job_o.data[3] = quantity_i[15:8];
        job_o.data[4] = quantity_i[7:0];
        job_o.data[5] = {quantity_i[6:0], 1'b0};
        job_o.len     = 4'd6;
        job_o.last    = (quantity_i == 16'd0);
        job_o.ovf     = |quantity_i[15:7];
        if (quantity_i != 16'd0) begin
          coll_d = COLL_REGS;
          left_d = quantity_i;
        end
      end else if (kind_i == KIND_READ_WRITE) begin
        job_o.data[3] = quantity_i[15:8];
        job_o.data[4] = quantity_i[7:0];
        job_o.data[5] = write_address_i[15:8];
        job_o.data[6] = write_address_i[7:0];
        job_o.data[7] = wq[15:8];
        job_o.data[8] = wq[7:0];
        job_o.data[9] = {wq[6:0], 1'b0};
        job_o.len     = 4'd10;
        job_o.last    = (wq == 16'd0);
        job_o.ovf     = |wq[15:7];
        if (wq != 16'd0) begin
          coll_d = COLL_REGS;
          left_d = wq;
        end
      end
    end else if (accept_i && (cmd_i == CMD_VALUE)) begin
      case (coll_q)
        COLL_COILS: begin
          left_d = left_dec;
          if ((pos_inc == 3'd0) || (left_dec == 16'd0)) begin
            job_valid_o   = 1'b1;
            job_o.data[0] = acc_set;
            job_o.len     = 4'd1;
            job_o.last    = (left_dec == 16'd0);
            acc_d         = '0;
            pos_d         = '0;
          end else begin
            acc_d = acc_set;
            pos_d = pos_inc;
          end
          if (left_dec == 16'd0) begin
            coll_d = COLL_IDLE;
          end
        end
        COLL_REGS: begin
          left_d        = left_dec;
          job_valid_o   = 1'b1;
          job_o.data[0] = element_i[15:8];
          job_o.data[1] = element_i[7:0];
          job_o.len     = 4'd2;
          job_o.last    = (left_dec == 16'd0);
          if (left_dec == 16'd0) begin
            coll_d = COLL_IDLE;
          end
        end
        default: begin
          coll_d = coll_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coll_q  <= COLL_IDLE;
      left_q  <= '0;
      acc_q   <= '0;
      pos_q   <= '0;
      slave_q <= '0;
    end else begin
      coll_q  <= coll_d;
      left_q  <= left_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      slave_q <= slave_d;
    end
  end

endmodule

[rtl/mrps_back.sv]
// ----------------------------------------------------------------------------
// Modbus request PDU serializer back end
// Takes byte jobs from the queue and sends one byte per transfer.
// ----------------------------------------------------------------------------
module mrps_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_empty_i,
  input  mrps_pkg::job_t job_i,
  output logic           job_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     data_byte_o,
  output logic [7:0]     target_slave_o,
  output logic           last_o,
  output logic           count_overflow_o
);
  import mrps_pkg::*;

  job_t       cur_q, cur_d;
  logic       cur_vld_q, cur_vld_d;
  logic [3:0] idx_q, idx_d;
  logic       out_vld_q, out_vld_d;
  logic [7:0] byte_q, byte_d, slv_q, slv_d;
  logic       last_q, last_d, ovf_q, ovf_d;
  logic       advance, at_end;

  assign empty_o          = !out_vld_q;
  assign data_byte_o      = byte_q;
  assign target_slave_o   = slv_q;
  assign last_o           = last_q;
  assign count_overflow_o = ovf_q;

  always_comb begin
    advance   = cur_vld_q && (!out_vld_q || pop_i);
    at_end    = (idx_q == cur_q.len - 4'd1);
    job_pop_o = !job_empty_i && (!cur_vld_q || (advance && at_end));

    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    idx_d     = idx_q;
    out_vld_d = out_vld_q && !pop_i;
    byte_d    = byte_q;
    slv_d     = slv_q;
    last_d    = last_q;
    ovf_d     = ovf_q;

    if (advance) begin
      out_vld_d = 1'b1;
      byte_d    = cur_q.data[idx_q];
      slv_d     = cur_q.slave;
      last_d    = at_end && cur_q.last;
      ovf_d     = at_end && cur_q.ovf;
      idx_d     = idx_q + 4'd1;
      if (at_end) begin
        cur_vld_d = 1'b0;
      end
    end
    if (job_pop_o) begin
      cur_d     = job_i;
      cur_vld_d = 1'b1;
      idx_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      idx_q     <= '0;
    end else begin
      cur_vld_q <= cur_vld_d;
      out_vld_q <= out_vld_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    byte_q <= byte_d;
    slv_q  <= slv_d;
    last_q <= last_d;
    ovf_q  <= ovf_d;
  end

endmodule

[rtl/modbus_request_pdu_serializer.sv]
// ----------------------------------------------------------------------------
// Modbus request PDU serializer
// Turns request headers and write values into a Modbus PDU byte stream.
// ----------------------------------------------------------------------------
// Every input item is taken while full is low. A header becomes
// a job of 5, 6 or 10 bytes, a register value a job of 2 bytes, and every
// eighth coil value (or the final one) a job of 1 byte; unknown kinds and
// values outside a request make no job. Jobs wait in a JobDepth-entry queue,
// and the back end sends one byte per cycle through its output register while
// pop is high or that register is empty. full rises only when the job queue is full.
module modbus_request_pdu_serializer #(
  parameter int unsigned JobDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        cmd_i,
  input  logic [3:0]  kind_i,
  input  logic [7:0]  slave_i,
  input  logic [15:0] address_i,
  input  logic [15:0] quantity_i,
  input  logic [15:0] single_value_i,
  input  logic [15:0] write_address_i,
  input  logic [15:0] write_quantity_i,
  input  logic [15:0] element_i,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  target_slave_o,
  output logic        last_o,
  output logic        count_overflow_o
);
  import mrps_pkg::*;

  logic accept;
  logic job_valid, job_pop, job_empty;
  job_t job_in, job_out;

  assign accept = push && !full;

  mrps_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .cmd_i            (cmd_i),
    .kind_i           (kind_i),
    .slave_i          (slave_i),
    .address_i        (address_i),
    .quantity_i       (quantity_i),
    .single_value_i   (single_value_i),
    .write_address_i  (write_address_i),
    .write_quantity_i (write_quantity_i),
    .element_i        (element_i),
    .job_valid_o      (job_valid),
    .job_o            (job_in)
  );

  mrps_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_valid),
    .wdata_i (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .empty_o (job_empty),
    .rdata_o (job_out)
  );

  mrps_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_empty_i      (job_empty),
    .job_i            (job_out),
    .job_pop_o        (job_pop),
    .pop_i            (pop),
    .empty_o          (empty),
    .data_byte_o      (data_byte_o),
    .target_slave_o   (target_slave_o),
    .last_o           (last_o),
    .count_overflow_o (count_overflow_o)
  );

endmodule

[rtl/mrps_checker.sv]
// ----------------------------------------------------------------------------
// Modbus request PDU serializer checker
// Port level checks on the serializer, attached by bind.
// ----------------------------------------------------------------------------
`include "modbus_request_pdu_serializer_defines.svh"

module mrps_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] data_byte_o,
  input logic [7:0] target_slave_o,
  input logic       last_o,
  input logic       count_overflow_o
);

  `MRPS_ASSERT_ALWAYS(a_empty_in_reset, clk_i, !rst_ni |-> empty)

  `MRPS_ASSERT_ALWAYS(a_clear_after_reset, clk_i, $rose(rst_ni) |-> (empty && !full))

  `MRPS_ASSERT(a_ovf_not_last, clk_i, rst_ni, (!empty && count_overflow_o) |-> !last_o)

  `MRPS_ASSERT(a_hold_stalled, clk_i, rst_ni, (!empty && !pop) |=> (!empty && $stable(data_byte_o) && $stable(target_slave_o) && $stable(last_o)))

endmodule

bind modbus_request_pdu_serializer mrps_checker u_checker (.*);
